@@ design/hmap_pkg.sv @@
package hmap_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 7;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 7'd48;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic [CNT_W-1:0] entry_count;
    logic             refused;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

@@ design/hmap_fifo.sv @@
module hmap_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ design/hmap_front.sv @@
module hmap_front #(
  parameter int CAPACITY = 64,
  parameter int IW       = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     func,
  input  logic [31:0]              key_id,
  input  logic [31:0]              key_hash,
  input  logic [31:0]              value_in,
  input  logic                     clearing,
  input  logic                     q_full,
  output logic                     q_push,
  output hmap_pkg::cmd_t           q_cmd,
  output logic [IW-1:0]            q_idx
);
  import hmap_pkg::*;

  localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

  generate
    if (IS_POW2) begin : g_mask
      // start slot is the low hash bits
      assign full   = clearing || q_full;
      assign q_push = push && !full;
      assign q_cmd  = '{func: func, key: key_id, value: value_in};
      assign q_idx  = key_hash[IW-1:0];
    end else begin : g_mod
      localparam logic [IW:0] CAP_W = (IW + 1)'(CAPACITY);

      logic          busy;
      logic          done;
      logic [1:0]    step;
      logic [31:0]   hsh;
      logic [IW-1:0] rem;
      cmd_t          cmd_r;
      logic [IW:0]   r;
      logic [31:0]   h;
      logic          accept;

      assign full   = clearing || busy;
      assign accept = push && !full;
      assign q_push = busy && done && !q_full;
      assign q_cmd  = cmd_r;
      assign q_idx  = rem;

      // restoring remainder, eight hash bits per cycle, MSB first
      always_comb begin
        r = {1'b0, rem};
        h = hsh;
        for (int i = 0; i < 8; i++) begin
          r = {r[IW-1:0], h[31]};
          h = {h[30:0], 1'b0};
          if (r >= CAP_W) begin
            r = r - CAP_W;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
          step <= 2'd0;
        end else if (accept) begin
          busy  <= 1'b1;
          done  <= 1'b0;
          step  <= 2'd0;
          rem   <= '0;
          hsh   <= key_hash;
          cmd_r <= '{func: func, key: key_id, value: value_in};
        end else if (busy && !done) begin
          rem  <= r[IW-1:0];
          hsh  <= h;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            done <= 1'b1;
          end
        end else if (q_push) begin
          busy <= 1'b0;
        end
      end
    end
  endgenerate

endmodule

@@ design/hmap_back.sv @@
module hmap_back #(
  parameter int CAPACITY = 64,
  parameter int IW       = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [hmap_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  hmap_pkg::cmd_t           q_cmd,
  input  logic [IW-1:0]            q_idx,
  input  logic                     out_full,
  output logic                     res_push,
  output hmap_pkg::res_t           res,
  output logic                     clearing
);
  import hmap_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  state_t           state;
  logic [IW-1:0]    clr_idx;
  logic [IW-1:0]    cur_idx;
  logic [IW-1:0]    n;
  cmd_t             cmd_r;
  logic [CNT_W-1:0] max_entries;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  slot_t            mem [CAPACITY];
  slot_t            rd_data;
  logic [IW-1:0]    rd_addr;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  slot_t            mem_wd;

  logic [IW-1:0]    idx_inc;
  logic             hit;
  logic             slot_empty;
  logic             last;
  logic             finish;
  logic             is_ins;
  logic             add;

  assign clearing   = (state == ST_CLEAR);
  assign idx_inc    = (cur_idx == LAST_IDX) ? '0 : cur_idx + 1'b1;
  // the next slot is read speculatively so a probe runs one slot per cycle
  assign rd_addr    = (state == ST_IDLE) ? q_idx : idx_inc;
  assign hit        = rd_data.valid && (rd_data.key == cmd_r.key);
  assign slot_empty = !rd_data.valid;
  assign last       = (n == LAST_IDX);
  assign finish     = (state == ST_CHECK) && (hit || slot_empty || last);
  assign is_ins     = (cmd_r.func == FUNC_INSERT);
  assign add        = is_ins && !hit && slot_empty && (count < max_entries);
  assign count_next = count + {{(CNT_W-1){1'b0}}, add};
  // output queue space is checked here, so the result always fits
  assign q_pop      = (state == ST_IDLE) && !q_empty && !out_full;

  assign res_push        = finish;
  assign res.found       = hit;
  assign res.value_out   = (!is_ins && hit) ? rd_data.value : '0;
  assign res.entry_count = count_next;
  assign res.refused     = is_ins && !hit && !add;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_idx;
    mem_wd = '{valid: 1'b1, key: cmd_r.key, value: cmd_r.value};
    if (clearing) begin
      mem_we = 1'b1;
      mem_wa = clr_idx;
      mem_wd = '0;
    end else if (finish && is_ins && (hit || add)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (cfg_wr_en) begin
      max_entries <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      count   <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            cmd_r   <= q_cmd;
            cur_idx <= q_idx;
            n       <= '0;
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (finish) begin
            count <= count_next;
            state <= ST_IDLE;
          end else begin
            cur_idx <= idx_inc;
            n       <= n + 1'b1;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  a_res_fits: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result pushed into a full output queue");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !clearing)
    else $error("request taken during clearing pass");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count)) || (count == $past(count) + 7'd1))
    else $error("key count moved by more than one");

  a_refuse_ins: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.refused) |-> (is_ins && !hit))
    else $error("refusal on a lookup or a present key");

endmodule

@@ design/linear_probe_hash_map.sv @@
// Channel  | Ports                                      | Handshake
// input    | func, key_id, key_hash, value_in           | push / full
// result   | found, value_out, entry_count, refused     | pop / empty
// config   | cfg_wr_data (max_entries)                  | cfg_wr_en
//
// An item is issued and then probes one slot per cycle; the slot memory
// has a single read port.
// With a CAPACITY that is not a power of two the front computes the hash
// remainder MSB first and takes no new request until it is passed on.
// After reset a clearing pass that zeroes every slot holds full high.
// Two-entry queues sit between front and back and before the result ports.
module linear_probe_hash_map #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       func,
  input  logic [31:0]                key_id,
  input  logic [31:0]                key_hash,
  input  logic [31:0]                value_in,
  output logic                       empty,
  input  logic                       pop,
  output logic                       found,
  output logic [31:0]                value_out,
  output logic [hmap_pkg::CNT_W-1:0] entry_count,
  output logic                       refused,
  input  logic                       cfg_wr_en,
  input  logic [hmap_pkg::CNT_W-1:0] cfg_wr_data
);
  import hmap_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int QW = $bits(cmd_t) + IW;

  logic          clearing;
  logic          fq_push;
  cmd_t          fq_cmd;
  logic [IW-1:0] fq_idx;
  logic          fq_full;
  logic [QW-1:0] bq_data;
  logic          bq_empty;
  logic          bq_pop;
  cmd_t          bq_cmd;
  logic [IW-1:0] bq_idx;
  logic          res_push;
  res_t          res;
  logic          out_full;
  res_t          out_res;

  hmap_front #(.CAPACITY(CAPACITY), .IW(IW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .func     (func),
    .key_id   (key_id),
    .key_hash (key_hash),
    .value_in (value_in),
    .clearing (clearing),
    .q_full   (fq_full),
    .q_push   (fq_push),
    .q_cmd    (fq_cmd),
    .q_idx    (fq_idx)
  );

  hmap_fifo #(.WIDTH(QW)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .din   ({fq_cmd, fq_idx}),
    .full  (fq_full),
    .pop   (bq_pop),
    .dout  (bq_data),
    .empty (bq_empty)
  );

  assign bq_cmd = bq_data[QW-1:IW];
  assign bq_idx = bq_data[IW-1:0];

  hmap_back #(.CAPACITY(CAPACITY), .IW(IW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (bq_empty),
    .q_pop       (bq_pop),
    .q_cmd       (bq_cmd),
    .q_idx       (bq_idx),
    .out_full    (out_full),
    .res_push    (res_push),
    .res         (res),
    .clearing    (clearing)
  );

  hmap_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_res),
    .empty (empty)
  );

  assign found       = out_res.found;
  assign value_out   = out_res.value_out;
  assign entry_count = out_res.entry_count;
  assign refused     = out_res.refused;

endmodule
